/* rtl/core/png_scanline_unfilter_assert.svh */
// Assertion macros shared by the scanline unfilter RTL.
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// Whenever the condition holds, the consequence must hold in the same cycle.
`define PSU_ASSERT_SAME(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Whenever the condition holds, the consequence must hold in the next cycle.
`define PSU_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

/* rtl/core/psu_pkg.sv */
// Shared constants, types and codes for the PNG scanline unfilter.
`timescale 1ns / 1ps
`default_nettype none

package psu_pkg;

    localparam int unsigned MAX_ROW_BYTES   = 32768;
    localparam int unsigned MAX_PIXEL_BYTES = 8;
    localparam int unsigned ROW_COUNT_LIMIT = 4096;

    localparam int unsigned ROW_ADDR_W = $clog2(MAX_ROW_BYTES);
    localparam int unsigned PIX_IDX_W  = $clog2(MAX_PIXEL_BYTES);
    localparam int unsigned COL_W      = 16;
    localparam int unsigned PIXB_W     = 4;
    localparam int unsigned ROWCNT_W   = 13;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_BYTES   = 2'd0,
        CFG_PIXEL_BYTES = 2'd1,
        CFG_ROW_COUNT   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    // What a beat held in the stage register does when it leaves.
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_DATA  = 2'd1,
        OP_ERROR = 2'd2
    } t_op;

    typedef struct packed {
        t_op                   op;
        t_filter               filter;
        logic                  upper_ok;
        logic [ROW_ADDR_W-1:0] addr;
        logic                  eor;
        logic                  eoi;
        logic [7:0]            sample;
    } t_item;

    typedef struct packed {
        logic [7:0] pixel;
        logic       eor;
        logic       eoi;
        logic       bad;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/psu_line_buf.sv */
// Previous-row line buffer: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module psu_line_buf (
    input  wire logic                            i_clk,
    input  wire logic                            i_wr_en,
    input  wire logic [psu_pkg::ROW_ADDR_W-1:0]  i_wr_addr,
    input  wire logic [7:0]                      i_wr_data,
    input  wire logic                            i_rd_en,
    input  wire logic [psu_pkg::ROW_ADDR_W-1:0]  i_rd_addr,
    output logic      [7:0]                      o_rd_data
);

    logic [7:0] r_mem [psu_pkg::MAX_ROW_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/core/psu_seq.sv */
// Row and column sequencer: classifies each accepted beat and loads the stage register.
`timescale 1ns / 1ps
`default_nettype none

module psu_seq (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  wire logic                              i_command,
    input  wire logic [7:0]                        i_data_byte,
    input  wire logic [psu_pkg::COL_W-1:0]         i_row_bytes,
    input  wire logic [psu_pkg::ROWCNT_W-1:0]      i_row_count,
    input  wire logic                              i_move,
    output psu_pkg::t_item                         o_item,
    output logic                                   o_item_vld,
    output logic                                   o_rd_en,
    output logic [psu_pkg::ROW_ADDR_W-1:0]         o_rd_addr
);

    logic [psu_pkg::COL_W-1:0]    r_column;
    logic [psu_pkg::ROWCNT_W-1:0] r_row_index;
    psu_pkg::t_filter             r_filter;
    logic                         r_halted;
    psu_pkg::t_item               r_item;
    logic                         r_item_vld;

    logic [psu_pkg::COL_W-1:0]    n_column;
    logic [psu_pkg::ROWCNT_W-1:0] n_row_index;
    psu_pkg::t_filter             n_filter;
    logic                         n_halted;
    psu_pkg::t_item               n_item;
    logic                         n_load;

    logic [psu_pkg::COL_W-1:0]    col_m1;
    logic                         row_end;
    logic                         img_end;
    logic                         is_data;

    assign col_m1  = r_column - psu_pkg::COL_W'(1);
    // The column register already holds the data index plus one.
    assign row_end = (r_column >= i_row_bytes);
    assign img_end = ({1'b0, r_row_index} + (psu_pkg::ROWCNT_W + 1)'(1))
                     >= {1'b0, i_row_count};

    always_comb begin
        n_column    = r_column;
        n_row_index = r_row_index;
        n_filter    = r_filter;
        n_halted    = r_halted;
        n_load      = 1'b0;
        is_data     = 1'b0;
        n_item.op       = psu_pkg::OP_CLEAR;
        n_item.filter   = r_filter;
        n_item.upper_ok = (r_row_index != '0);
        n_item.addr     = col_m1[psu_pkg::ROW_ADDR_W-1:0];
        n_item.eor      = row_end;
        n_item.eoi      = row_end && img_end;
        n_item.sample   = i_data_byte;
        if (i_command) begin
            n_column    = '0;
            n_row_index = '0;
            n_filter    = psu_pkg::FILT_NONE;
            n_halted    = 1'b0;
            n_load      = 1'b1;
        end else if (r_halted || (r_row_index >= i_row_count)) begin
            n_load = 1'b0;
        end else if (r_column == '0) begin
            n_load = 1'b1;
            if (i_data_byte > 8'(psu_pkg::FILT_PAETH)) begin
                n_halted  = 1'b1;
                n_item.op = psu_pkg::OP_ERROR;
            end else begin
                n_filter  = psu_pkg::t_filter'(i_data_byte[2:0]);
                n_column  = psu_pkg::COL_W'(1);
            end
        end else begin
            n_load    = 1'b1;
            is_data   = 1'b1;
            n_item.op = psu_pkg::OP_DATA;
            if (row_end) begin
                n_row_index = r_row_index + psu_pkg::ROWCNT_W'(1);
                n_column    = '0;
            end else begin
                n_column = r_column + psu_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_row_index <= '0;
            r_filter    <= psu_pkg::FILT_NONE;
            r_halted    <= 1'b0;
            r_item_vld  <= 1'b0;
        end else if (i_accept) begin
            r_column    <= n_column;
            r_row_index <= n_row_index;
            r_filter    <= n_filter;
            r_halted    <= n_halted;
            r_item_vld  <= n_load;
        end else if (i_move) begin
            r_item_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= n_item;
        end
    end

    assign o_item     = r_item;
    assign o_item_vld = r_item_vld;
    assign o_rd_en    = i_accept && is_data;
    assign o_rd_addr  = col_m1[psu_pkg::ROW_ADDR_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/psu_recon.sv */
// Reconstruction stage: neighbor history, predictor and modulo-256 add.
`timescale 1ns / 1ps
`default_nettype none

module psu_recon (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire psu_pkg::t_item                    i_item,
    input  wire logic                              i_move,
    input  wire logic [7:0]                        i_rd_data,
    input  wire logic [psu_pkg::PIXB_W-1:0]        i_pixel_bytes,
    output psu_pkg::t_result                       o_res,
    output logic                                   o_wr_en,
    output logic [psu_pkg::ROW_ADDR_W-1:0]         o_wr_addr,
    output logic [7:0]                             o_wr_data
);

    logic [7:0] r_left  [psu_pkg::MAX_PIXEL_BYTES];
    logic [7:0] r_uleft [psu_pkg::MAX_PIXEL_BYTES];

    logic [psu_pkg::PIX_IDX_W-1:0] tap;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [8:0] avg_sum;
    logic [7:0] pred;
    logic [7:0] recon;

    function automatic logic [7:0] paeth(input logic [7:0] pa_a, input logic [7:0] pa_b,
                                         input logic [7:0] pa_c);
        logic [7:0] da;
        logic [7:0] db;
        logic [9:0] s;
        logic [9:0] t;
        logic [9:0] dc;
        logic [7:0] pick;
        // Distances to p = a + b - c, without forming p itself.
        da = (pa_b >= pa_c) ? (pa_b - pa_c) : (pa_c - pa_b);
        db = (pa_a >= pa_c) ? (pa_a - pa_c) : (pa_c - pa_a);
        s  = {2'b00, pa_a} + {2'b00, pa_b};
        t  = {1'b0, pa_c, 1'b0};
        dc = (s >= t) ? (s - t) : (t - s);
        if (({2'b00, da} <= {2'b00, db}) && ({2'b00, da} <= dc)) begin
            pick = pa_a;
        end else if ({2'b00, db} <= dc) begin
            pick = pa_b;
        end else begin
            pick = pa_c;
        end
        return pick;
    endfunction

    assign tap     = psu_pkg::PIX_IDX_W'(i_pixel_bytes - psu_pkg::PIXB_W'(1));
    assign a       = r_left[tap];
    assign c       = r_uleft[tap];
    assign b       = i_item.upper_ok ? i_rd_data : 8'd0;
    assign avg_sum = {1'b0, a} + {1'b0, b};

    always_comb begin
        case (i_item.filter)
            psu_pkg::FILT_SUB:   pred = a;
            psu_pkg::FILT_UP:    pred = b;
            psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
            psu_pkg::FILT_PAETH: pred = paeth(a, b, c);
            default:             pred = 8'd0;
        endcase
    end

    assign recon = i_item.sample + pred;

    always_comb begin
        o_res.pixel = 8'd0;
        o_res.eor   = 1'b0;
        o_res.eoi   = 1'b0;
        o_res.bad   = 1'b0;
        case (i_item.op)
            psu_pkg::OP_DATA: begin
                o_res.pixel = recon;
                o_res.eor   = i_item.eor;
                o_res.eoi   = i_item.eoi;
            end
            psu_pkg::OP_ERROR: begin
                o_res.bad = 1'b1;
            end
            default: begin
                o_res.bad = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < psu_pkg::MAX_PIXEL_BYTES; k++) begin
                r_left[k]  <= 8'd0;
                r_uleft[k] <= 8'd0;
            end
        end else if (i_move && (i_item.op == psu_pkg::OP_CLEAR)) begin
            for (int k = 0; k < psu_pkg::MAX_PIXEL_BYTES; k++) begin
                r_left[k]  <= 8'd0;
                r_uleft[k] <= 8'd0;
            end
        end else if (i_move && (i_item.op == psu_pkg::OP_DATA)) begin
            for (int k = psu_pkg::MAX_PIXEL_BYTES - 1; k > 0; k--) begin
                r_left[k]  <= r_left[k-1];
                r_uleft[k] <= r_uleft[k-1];
            end
            r_left[0]  <= recon;
            r_uleft[0] <= b;
        end
    end

    assign o_wr_en   = i_move && (i_item.op == psu_pkg::OP_DATA);
    assign o_wr_addr = i_item.addr;
    assign o_wr_data = recon;

endmodule

`default_nettype wire

/* rtl/core/png_scanline_unfilter.sv */
// PNG scanline unfilter: registers, handshake and output register around the datapath.
//
// Usage: inflated scanline bytes enter on the input channel, one beat per byte, with
// i_command high for a start-of-image beat. The first byte of each row picks the filter;
// each later byte of the row gives one reconstructed byte on the output channel, flagged
// with end of row, end of image, or bad filter for a filter type above four (after which
// every beat is dropped until a start beat). Bytes past the configured row count give
// no output. The user must write configuration through the write port only while the
// block is idle; the block itself does not enforce this. Throughput: one byte per
// cycle while i_out_stall is low. The line buffer is read at accept as the stage
// register loads; predictor and adder run between stage and output registers.
// Reset: row, column, error state and neighbor history clear, all three registers go to
// one; line buffer contents are undefined and never cleared, since a row only reads
// entries the previous row wrote.
// Stall: the output register holds its beat while i_out_stall is high; the stage then
// fills and o_in_stall rises in the same cycle, so no beat is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module png_scanline_unfilter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [psu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [psu_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_command,
    input  wire logic [7:0]                        i_data_byte,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic      [7:0]                        o_pixel_byte,
    output logic                                   o_end_of_row,
    output logic                                   o_end_of_image,
    output logic                                   o_bad_filter
);

    logic [psu_pkg::COL_W-1:0]    r_row_bytes;
    logic [psu_pkg::PIXB_W-1:0]   r_pixel_bytes;
    logic [psu_pkg::ROWCNT_W-1:0] r_row_count;
    logic                         r_out_vld;
    psu_pkg::t_result             r_out;

    logic [psu_pkg::COL_W-1:0]    eff_row_bytes;
    logic [psu_pkg::PIXB_W-1:0]   eff_pixel_bytes;
    logic [psu_pkg::ROWCNT_W-1:0] eff_row_count;

    psu_pkg::t_item               item;
    logic                         item_vld;
    psu_pkg::t_result             res;
    logic                         accept;
    logic                         move;
    logic                         rd_en;
    logic [psu_pkg::ROW_ADDR_W-1:0] rd_addr;
    logic [7:0]                   rd_data;
    logic                         wr_en;
    logic [psu_pkg::ROW_ADDR_W-1:0] wr_addr;
    logic [7:0]                   wr_data;

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes   <= psu_pkg::COL_W'(1);
            r_pixel_bytes <= psu_pkg::PIXB_W'(1);
            r_row_count   <= psu_pkg::ROWCNT_W'(1);
        end else if (i_cfg_we) begin
            case (psu_pkg::t_cfg_idx'(i_cfg_index))
                psu_pkg::CFG_ROW_BYTES:
                    r_row_bytes <= i_cfg_data[psu_pkg::COL_W-1:0];
                psu_pkg::CFG_PIXEL_BYTES:
                    r_pixel_bytes <= i_cfg_data[psu_pkg::PIXB_W-1:0];
                psu_pkg::CFG_ROW_COUNT:
                    r_row_count <= i_cfg_data[psu_pkg::ROWCNT_W-1:0];
                default: begin
                    r_row_bytes <= r_row_bytes;
                end
            endcase
        end
    end

    // Zero reads as one, and values above the supported maximum read as the maximum.
    always_comb begin
        if (r_row_bytes == '0) begin
            eff_row_bytes = psu_pkg::COL_W'(1);
        end else if (r_row_bytes > psu_pkg::COL_W'(psu_pkg::MAX_ROW_BYTES)) begin
            eff_row_bytes = psu_pkg::COL_W'(psu_pkg::MAX_ROW_BYTES);
        end else begin
            eff_row_bytes = r_row_bytes;
        end
        if (r_pixel_bytes == '0) begin
            eff_pixel_bytes = psu_pkg::PIXB_W'(1);
        end else if (r_pixel_bytes > psu_pkg::PIXB_W'(psu_pkg::MAX_PIXEL_BYTES)) begin
            eff_pixel_bytes = psu_pkg::PIXB_W'(psu_pkg::MAX_PIXEL_BYTES);
        end else begin
            eff_pixel_bytes = r_pixel_bytes;
        end
        if (r_row_count == '0) begin
            eff_row_count = psu_pkg::ROWCNT_W'(1);
        end else if (r_row_count > psu_pkg::ROWCNT_W'(psu_pkg::ROW_COUNT_LIMIT)) begin
            eff_row_count = psu_pkg::ROWCNT_W'(psu_pkg::ROW_COUNT_LIMIT);
        end else begin
            eff_row_count = r_row_count;
        end
    end

    // A beat without a result leaves the stage at once; one with a result needs
    // room in the output register.
    assign move = item_vld && ((item.op == psu_pkg::OP_CLEAR) || !r_out_vld || !i_out_stall);
    assign o_in_stall = item_vld && !move;
    assign accept     = i_in_valid && !o_in_stall;

    psu_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .i_row_bytes (eff_row_bytes),
        .i_row_count (eff_row_count),
        .i_move      (move),
        .o_item      (item),
        .o_item_vld  (item_vld),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr)
    );

    psu_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    psu_recon u_recon (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item),
        .i_move        (move),
        .i_rd_data     (rd_data),
        .i_pixel_bytes (eff_pixel_bytes),
        .o_res         (res),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (move && (item.op != psu_pkg::OP_CLEAR)) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move && (item.op != psu_pkg::OP_CLEAR)) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_pixel_byte   = r_out.pixel;
    assign o_end_of_row   = r_out.eor;
    assign o_end_of_image = r_out.eoi;
    assign o_bad_filter   = r_out.bad;

`include "png_scanline_unfilter_assert.svh"

    `PSU_ASSERT_SAME(a_stall_needs_stage, i_clk, i_rst_n, o_in_stall, item_vld, "input stall without a held beat")
    `PSU_ASSERT_SAME(a_eoi_has_eor, i_clk, i_rst_n, o_out_valid && o_end_of_image, o_end_of_row, "end of image without end of row")
    `PSU_ASSERT_SAME(a_bad_is_blank, i_clk, i_rst_n, o_out_valid && o_bad_filter, (o_pixel_byte == 8'd0) && !o_end_of_row && !o_end_of_image, "bad filter beat carries data")
    `PSU_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, move && (item.op != psu_pkg::OP_CLEAR), o_out_valid, "result beat lost on the way out")

endmodule

`default_nettype wire

/* sim/unfilter_checker.sv */
// Checker for the scanline unfilter: predicts each reconstructed beat and compares it.
`timescale 1ns / 1ps

module unfilter_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [psu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic                             i_command,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [7:0]                       i_pixel_byte,
    input  logic                             i_end_of_row,
    input  logic                             i_end_of_image,
    input  logic                             i_bad_filter,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_bad_results,
    output int                               o_image_ends
);
    import psu_pkg::*;

    logic [7:0]  prior_row   [MAX_ROW_BYTES];
    logic [7:0]  left_hist   [MAX_PIXEL_BYTES];
    logic [7:0]  upleft_hist [MAX_PIXEL_BYTES];
    int unsigned column;
    int unsigned row_idx;
    t_filter     filter_sel;
    bit          halted;

    logic [15:0] row_bytes_reg;
    logic [3:0]  pixel_bytes_reg;
    logic [12:0] row_count_reg;

    t_result     expected_pixels [$];
    t_result     oldest;

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Nearest of left, above and above-left to left + above - above-left; ties go to
    // left, then above.
    function automatic logic [7:0] paeth_nearest(input logic [7:0] a, input logic [7:0] b,
                                                 input logic [7:0] c);
        int ia, ib, ic, p, da, db, dc;
        ia = a;
        ib = b;
        ic = c;
        p  = ia + ib - ic;
        da = (p > ia) ? p - ia : ia - p;
        db = (p > ib) ? p - ib : ib - p;
        dc = (p > ic) ? p - ic : ic - p;
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
    endfunction

    task automatic clear_history();
        int k;
        for (k = 0; k < MAX_PIXEL_BYTES; k++) begin
            left_hist[k]   = 8'd0;
            upleft_hist[k] = 8'd0;
        end
    endtask

    task automatic unfilter_byte(input logic cmd, input logic [7:0] x);
        int unsigned rb, pb, rc, d;
        int          k;
        logic [7:0]  a, b, c, pred, r;
        t_result     e;
        rb = clamp_to(row_bytes_reg, 1, MAX_ROW_BYTES);
        pb = clamp_to(pixel_bytes_reg, 1, MAX_PIXEL_BYTES);
        rc = clamp_to(row_count_reg, 1, ROW_COUNT_LIMIT);
        if (cmd) begin
            row_idx    = 0;
            column     = 0;
            filter_sel = FILT_NONE;
            halted     = 1'b0;
            clear_history();
        end else if (!halted && row_idx < rc) begin
            if (column == 0) begin
                if (x > 8'd4) begin
                    halted = 1'b1;
                    e      = '0;
                    e.bad  = 1'b1;
                    expected_pixels.push_back(e);
                end else begin
                    filter_sel = t_filter'(x[2:0]);
                    clear_history();
                    column = 1;
                end
            end else begin
                d = column - 1;
                if (d >= MAX_ROW_BYTES) d = MAX_ROW_BYTES - 1;
                a = left_hist[pb-1];
                c = upleft_hist[pb-1];
                b = (row_idx != 0) ? prior_row[d] : 8'd0;
                case (filter_sel)
                    FILT_SUB:   pred = a;
                    FILT_UP:    pred = b;
                    FILT_AVG:   pred = ({1'b0, a} + {1'b0, b}) >> 1;
                    FILT_PAETH: pred = paeth_nearest(a, b, c);
                    default:    pred = 8'd0;
                endcase
                r = x + pred;
                for (k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
                    left_hist[k]   = left_hist[k-1];
                    upleft_hist[k] = upleft_hist[k-1];
                end
                left_hist[0]   = r;
                upleft_hist[0] = b;
                prior_row[d]   = r;
                e = '0;
                e.pixel = r;
                if (d + 1 >= rb) begin
                    e.eor   = 1'b1;
                    e.eoi   = (row_idx + 1 >= rc);
                    row_idx = row_idx + 1;
                    column  = 0;
                end else begin
                    column = column + 1;
                end
                expected_pixels.push_back(e);
            end
        end
    endtask

    task automatic report(input string msg);
        o_fail_count = o_fail_count + 1;
        $display("unfilter mismatch: %s", msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            column          = 0;
            row_idx         = 0;
            filter_sel      = FILT_NONE;
            halted          = 1'b0;
            row_bytes_reg   = 16'd1;
            pixel_bytes_reg = 4'd1;
            row_count_reg   = 13'd1;
            clear_history();
            expected_pixels.delete();
            o_fail_count    = 0;
            o_checked       = 0;
            o_bad_results   = 0;
            o_image_ends    = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_checked = o_checked + 1;
                if (expected_pixels.size() == 0) begin
                    report($sformatf("result beat %0d arrived with nothing expected",
                                     o_checked));
                end else begin
                    oldest = expected_pixels.pop_front();
                    if (i_pixel_byte !== oldest.pixel)
                        report($sformatf("beat %0d pixel_byte %0h, expected %0h",
                                         o_checked, i_pixel_byte, oldest.pixel));
                    if (i_end_of_row !== oldest.eor)
                        report($sformatf("beat %0d end_of_row %0b, expected %0b",
                                         o_checked, i_end_of_row, oldest.eor));
                    if (i_end_of_image !== oldest.eoi)
                        report($sformatf("beat %0d end_of_image %0b, expected %0b",
                                         o_checked, i_end_of_image, oldest.eoi));
                    if (i_bad_filter !== oldest.bad)
                        report($sformatf("beat %0d bad_filter %0b, expected %0b",
                                         o_checked, i_bad_filter, oldest.bad));
                    if (oldest.bad) o_bad_results = o_bad_results + 1;
                    if (oldest.eoi) o_image_ends = o_image_ends + 1;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROW_BYTES:   row_bytes_reg   = i_cfg_data[15:0];
                    CFG_PIXEL_BYTES: pixel_bytes_reg = i_cfg_data[3:0];
                    CFG_ROW_COUNT:   row_count_reg   = i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) unfilter_byte(i_command, i_data_byte);
        end
        o_pending = expected_pixels.size();
    end

endmodule

/* sim/tb_top.sv */
// Testbench top for the scanline unfilter: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;
    import psu_pkg::*;

    // Longest run of cycles with no beat on either channel that a healthy run can show,
    // covering random stalls and the short drains before register writes.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_BEATS   = 160;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  in_cmd;
    logic [7:0]            in_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            pixel_byte;
    logic                  end_of_row;
    logic                  end_of_image;
    logic                  bad_filter;

    int chk_fails, chk_pending, chk_checked, chk_bad, chk_image_ends;
    int send_idle, recv_idle;
    int beats_sent, images, idle_cycles;

    png_scanline_unfilter dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_command      (in_cmd),
        .i_data_byte    (in_byte),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_pixel_byte   (pixel_byte),
        .o_end_of_row   (end_of_row),
        .o_end_of_image (end_of_image),
        .o_bad_filter   (bad_filter)
    );

    unfilter_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_command      (in_cmd),
        .i_data_byte    (in_byte),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_pixel_byte   (pixel_byte),
        .i_end_of_row   (end_of_row),
        .i_end_of_image (end_of_image),
        .i_bad_filter   (bad_filter),
        .o_fail_count   (chk_fails),
        .o_pending      (chk_pending),
        .o_checked      (chk_checked),
        .o_bad_results  (chk_bad),
        .o_image_ends   (chk_image_ends)
    );

    always #1 clk = ~clk;

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic cmd, input logic [7:0] b);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent = beats_sent + 1;
        @(negedge clk);
    endtask

    // Drain all expected beats, then give the pipeline time to finish beats that
    // produce nothing.
    task automatic wait_quiet(input int settle);
        in_valid <= 1'b0;
        while (chk_pending != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic cfg_beat(input t_cfg_idx idx, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
    endtask

    task automatic write_regs(input logic [2:0] mask, input logic [15:0] rb,
                              input logic [15:0] pb, input logic [15:0] rc);
        wait_quiet(4);
        if (mask[0]) cfg_beat(CFG_ROW_BYTES, rb);
        if (mask[1]) cfg_beat(CFG_PIXEL_BYTES, pb);
        if (mask[2]) cfg_beat(CFG_ROW_COUNT, rc);
        cfg_we <= 1'b0;
    endtask

    // One image: program all registers, start, then rows of filter byte plus samples.
    // Row length is only ever lowered mid-image, so no row reads a line buffer entry
    // that the row before it did not write.
    task automatic run_image(input logic [15:0] rb, input logic [15:0] pb,
                             input logic [15:0] rc, input bit noisy,
                             input int unsigned extra_rows);
        int unsigned rb_now, rows, row_len, lowered, r, i;
        logic [7:0]  kind;
        write_regs(3'b111, rb, pb, rc);
        images = images + 1;
        send_beat(1'b1, rand_byte());
        rb_now = (rb == 0) ? 1 : ((rb > MAX_ROW_BYTES) ? MAX_ROW_BYTES : rb);
        rows   = (rc[12:0] == 0) ? 1 : ((rc[12:0] > ROW_COUNT_LIMIT) ? ROW_COUNT_LIMIT
                                                                    : rc[12:0]);
        rows   = rows + extra_rows;
        for (r = 0; r < rows; r++) begin
            if (noisy && $urandom_range(19) == 0) kind = 8'($urandom_range(5, 255));
            else kind = 8'($urandom_range(0, 4));
            send_beat(1'b0, kind);
            row_len = rb_now;
            for (i = 0; i < row_len; i++) begin
                if (noisy) begin
                    if ($urandom_range(99) == 0) send_beat(1'b1, rand_byte());
                    if ($urandom_range(99) < 2) begin
                        case ($urandom_range(2))
                            0: begin
                                lowered = $urandom_range(0, rb_now);
                                write_regs(3'b001, 16'(lowered), 16'd0, 16'd0);
                                rb_now = (lowered == 0) ? 1 : lowered;
                            end
                            1: write_regs(3'b010, 16'd0, 16'($urandom_range(0, 15)), 16'd0);
                            default: write_regs(3'b100, 16'd0, 16'd0,
                                                16'($urandom_range(0, 8)));
                        endcase
                    end
                end
                send_beat(1'b0, rand_byte());
            end
        end
    endtask

    task automatic run_random(input int unsigned goal);
        int unsigned first, sel;
        logic [15:0] rb;
        first = beats_sent;
        while (beats_sent - first < goal) begin
            sel = $urandom_range(9);
            if (sel == 0) rb = 16'd0;
            else if (sel < 3) rb = 16'($urandom_range(9, 40));
            else rb = 16'($urandom_range(1, 8));
            run_image(rb, 16'($urandom_range(0, 15)), 16'($urandom_range(0, 5)), 1'b1,
                      ($urandom_range(3) == 0) ? 1 : 0);
        end
    endtask

    initial begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_ROW_BYTES;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_cmd      = 1'b0;
        in_byte     = 8'd0;
        out_stall   = 1'b0;
        send_idle   = 19;
        recv_idle   = 63;
        beats_sent  = 0;
        images      = 0;
        idle_cycles = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: one-byte rows, one row per image; the second row is dropped.
        send_beat(1'b0, 8'(FILT_NONE));
        send_beat(1'b0, 8'hFF);
        send_beat(1'b0, 8'h00);

        // Sub, Up, Average and Paeth once each, each row reading the one before it.
        write_regs(3'b111, 16'd2, 16'd0, 16'd4);
        send_beat(1'b1, 8'hA5);
        send_beat(1'b0, 8'(FILT_SUB));
        send_beat(1'b0, 8'h80);
        send_beat(1'b0, 8'hFF);
        send_beat(1'b0, 8'(FILT_UP));
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'h7F);
        send_beat(1'b0, 8'(FILT_AVG));
        send_beat(1'b0, 8'hFF);
        send_beat(1'b0, 8'h01);
        send_beat(1'b0, 8'(FILT_PAETH));
        send_beat(1'b0, 8'h10);
        send_beat(1'b0, 8'hF0);
        // Past the row count even an invalid filter byte is simply dropped.
        send_beat(1'b0, 8'd7);

        // Unknown filter halts until the next start; the byte after it is ignored.
        send_beat(1'b1, 8'h00);
        send_beat(1'b0, 8'd5);
        send_beat(1'b0, 8'(FILT_NONE));

        // Shorten the row while it is in progress: the next sample closes it.
        send_beat(1'b1, 8'hFF);
        send_beat(1'b0, 8'(FILT_NONE));
        send_beat(1'b0, 8'h11);
        write_regs(3'b001, 16'd1, 16'd0, 16'd0);
        send_beat(1'b0, 8'h22);
        send_beat(1'b0, 8'(FILT_PAETH));
        send_beat(1'b0, 8'h44);

        run_random(RANDOM_BEATS);

        wait_quiet(4);
        send_idle = 63;
        recv_idle = 19;
        run_random(RANDOM_BEATS);

        wait_quiet(4);
        send_idle = 0;
        recv_idle = 0;
        run_random(RANDOM_BEATS);

        // Widest pixels, registers above their maximum cut short by a start, and zeros.
        run_image(16'd20, 16'd8, 16'd2, 1'b0, 0);
        write_regs(3'b111, 16'hFFFF, 16'd15, 16'h1FFF);
        send_beat(1'b1, 8'h3C);
        send_beat(1'b0, 8'(FILT_PAETH));
        repeat (8) send_beat(1'b0, rand_byte());
        run_image(16'd0, 16'd0, 16'd0, 1'b0, 1);

        wait_quiet(8);
        $display("Run covered %0d input beats over %0d images, row lengths 1 to 40.",
                 beats_sent, images);
        $display("Checked %0d result beats: %0d image ends, %0d bad filter errors.",
                 chk_checked, chk_image_ends, chk_bad);
        if (chk_fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches found", chk_fails);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
